### rtl/core/mms_pkg.sv
package mms_pkg;

  localparam int DataW  = 32;
  localparam int WordW  = 34;
  localparam int CapW   = 8;
  localparam int OpW    = 2;
  localparam int StatW  = 2;

  localparam logic [OpW-1:0] OP_PUSH  = 2'd0;
  localparam logic [OpW-1:0] OP_POP   = 2'd1;
  localparam logic [OpW-1:0] OP_QUERY = 2'd2;

  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd2;

  localparam logic [CapW-1:0] CAP_RESET = 8'd128;

  localparam logic signed [DataW-1:0] INT_MAX = 32'sh7fff_ffff;
  localparam logic signed [DataW-1:0] INT_MIN = 32'sh8000_0000;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // latch the transaction and read the top word
    logic commit;  // apply the operation and load the result register
  } cmd_t;

endpackage

### rtl/core/min_max_stack.sv
// min_max_stack: LIFO of signed 32-bit values that also tracks the running
// minimum and maximum of the entries held.
//
// Input channel (in_valid_i / in_stall_o): one transaction carries an
// operation (push, pop, query) and a push value. Output channel
// (out_valid_o / out_stall_i): one result transaction per input, with the
// popped value, min, max, entry count and a status code.
//
// The read of the top stack word is registered when the input is accepted;
// the operation is then applied and the result register loaded as soon as
// the output register is free. The block holds one transaction at a time, so
// it takes no new item until the last one has been committed.
//
// A finished result sits in the output register; while the receiver stalls
// it holds, and the block still accepts and reads the next item, committing
// it as soon as the output register frees up.
//
// Reset clears the entry count, sets min to the largest and max to the
// smallest 32-bit value and capacity to 128. The stack memory is not cleared.
// Write cfg_capacity_limit_i only while the block is idle.
module min_max_stack #(
  parameter int DEPTH = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mms_pkg::CapW-1:0]          cfg_capacity_limit_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mms_pkg::OpW-1:0]           operation_i,
  input  logic signed [mms_pkg::DataW-1:0]  push_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [mms_pkg::DataW-1:0]  popped_value_o,
  output logic signed [mms_pkg::DataW-1:0]  current_min_o,
  output logic signed [mms_pkg::DataW-1:0]  current_max_o,
  output logic [mms_pkg::CapW-1:0]          entry_count_o,
  output logic [mms_pkg::StatW-1:0]         status_o
);
  import mms_pkg::*;

  cmd_t cmd;

  // Sequencing: accept, read top word, commit into the output register
  mms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Stack memory, min/max registers and result register
  mms_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_capacity_limit_i),
    .operation_i    (operation_i),
    .push_value_i   (push_value_i),
    .popped_value_o (popped_value_o),
    .current_min_o  (current_min_o),
    .current_max_o  (current_max_o),
    .entry_count_o  (entry_count_o),
    .status_o       (status_o)
  );

endmodule

### rtl/core/mms_ctrl.sv
module mms_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output mms_pkg::cmd_t cmd_o
);
  import mms_pkg::*;

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_EXEC = 1'b1;

  logic [0:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free     = !out_valid_q || !out_stall_i;
  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.commit = (state_q == S_EXEC) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/core/mms_dp.sv
module mms_dp #(
  parameter int DEPTH = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mms_pkg::cmd_t                       cmd_i,
  input  logic                                cfg_we_i,
  input  logic [mms_pkg::CapW-1:0]            cfg_data_i,
  input  logic [mms_pkg::OpW-1:0]             operation_i,
  input  logic signed [mms_pkg::DataW-1:0]    push_value_i,
  output logic signed [mms_pkg::DataW-1:0]    popped_value_o,
  output logic signed [mms_pkg::DataW-1:0]    current_min_o,
  output logic signed [mms_pkg::DataW-1:0]    current_max_o,
  output logic [mms_pkg::CapW-1:0]            entry_count_o,
  output logic [mms_pkg::StatW-1:0]           status_o
);
  import mms_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > CapW) ? CW : CapW;

  logic [WordW-1:0] mem [DEPTH];
  logic [WordW-1:0] rd_q;

  logic [OpW-1:0]          op_q;
  logic signed [DataW-1:0] val_q;
  logic [CapW-1:0]         cap_q;
  logic [CW-1:0]           count_q, count_d;
  logic signed [DataW-1:0] min_q, min_d, max_q, max_d;

  logic signed [DataW-1:0] pop_d;
  logic [StatW-1:0]        stat_d;
  logic                    we;
  logic [AW-1:0]           wa, ra;
  logic signed [WordW-1:0] wd;

  logic                    full;
  logic signed [WordW-1:0] x_ext, min_ext, max_ext, word;
  logic signed [WordW-1:0] x2, min2, max2;

  assign ra      = AW'(count_q - 1'b1);
  assign wa      = AW'(count_q);
  assign full    = (XW'(count_q) >= XW'(cap_q)) || (count_q == CW'(DEPTH));
  assign x_ext   = WordW'(val_q);
  assign min_ext = WordW'(min_q);
  assign max_ext = WordW'(max_q);
  assign x2      = {val_q[DataW-1], val_q, 1'b0};
  assign min2    = {min_q[DataW-1], min_q, 1'b0};
  assign max2    = {max_q[DataW-1], max_q, 1'b0};
  assign word    = $signed(rd_q);

  always_comb begin
    count_d = count_q;
    min_d   = min_q;
    max_d   = max_q;
    pop_d   = '0;
    stat_d  = ST_OK;
    we      = 1'b0;
    wd      = x_ext;
    case (op_q)
      OP_PUSH: begin
        if (full) begin
          stat_d = ST_FULL;
        end else begin
          we      = 1'b1;
          count_d = CW'(count_q + 1'b1);
          if (count_q == '0) begin
            min_d = val_q;
            max_d = val_q;
          end else if (val_q < min_q) begin
            wd    = x2 - min_ext;
            min_d = val_q;
          end else if (val_q > max_q) begin
            wd    = x2 - max_ext;
            max_d = val_q;
          end
        end
      end
      OP_POP: begin
        if (count_q == '0) begin
          stat_d = ST_EMPTY;
        end else begin
          count_d = CW'(count_q - 1'b1);
          pop_d   = word[DataW-1:0];
          // encoded word: recover the previous extreme
          if (word < min_ext) begin
            pop_d = min_q;
            min_d = DataW'(min2 - word);
          end else if (word > max_ext) begin
            pop_d = max_q;
            max_d = DataW'(max2 - word);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && we) mem[wa] <= wd;
    if (cmd_i.load) rd_q <= mem[ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= operation_i;
      val_q <= push_value_i;
    end
    if (cmd_i.commit) begin
      popped_value_o <= pop_d;
      current_min_o  <= min_d;
      current_max_o  <= max_d;
      entry_count_o  <= CapW'(count_d);
      status_o       <= stat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      count_q <= '0;
      min_q   <= INT_MAX;
      max_q   <= INT_MIN;
    end else begin
      if (cfg_we_i) cap_q <= cfg_data_i;
      if (cmd_i.commit) begin
        count_q <= count_d;
        min_q   <= min_d;
        max_q   <= max_d;
      end
    end
  end

endmodule

### rtl/core/mms_checker.sv
module mms_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [mms_pkg::DataW-1:0]  popped_value_o,
  input logic [mms_pkg::CapW-1:0]          entry_count_o,
  input logic [mms_pkg::StatW-1:0]         status_o
);
  import mms_pkg::*;

  // A stalled result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(popped_value_o) && $stable(status_o)
      && $stable(entry_count_o))
    else $error("result changed while stalled");

  // One transaction in flight: stall right after an accept
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction taken while busy");

  // A refused operation returns no popped value
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> popped_value_o == '0)
    else $error("refused operation returned a value");

  // Pop refused only on an empty stack
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> entry_count_o == '0)
    else $error("empty status with entries held");

endmodule

bind min_max_stack mms_checker u_mms_checker (.*);

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mms_pkg::*;

  localparam int DEPTH      = 128;
  localparam int TIMEOUT_NS = 400_000;
  localparam int MAX_PRINTS = 200;

  // Operation code the block does not define; it must behave as a query
  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

  // One result transaction as the output channel presents it
  typedef struct packed {
    logic signed [DataW-1:0] popped;
    logic signed [DataW-1:0] min_v;
    logic signed [DataW-1:0] max_v;
    logic [CapW-1:0]         count;
    logic [StatW-1:0]        status;
  } stack_result_t;

  logic                     clk_i                = 1'b0;
  logic                     rst_ni               = 1'b0;
  logic                     cfg_we_i             = 1'b0;
  logic [CapW-1:0]          cfg_capacity_limit_i = CAP_RESET;
  logic                     in_valid_i           = 1'b0;
  logic                     in_stall_o;
  logic [OpW-1:0]           operation_i          = OP_QUERY;
  logic signed [DataW-1:0]  push_value_i         = '0;
  logic                     out_valid_o;
  logic                     out_stall_i          = 1'b0;
  logic signed [DataW-1:0]  popped_value_o;
  logic signed [DataW-1:0]  current_min_o;
  logic signed [DataW-1:0]  current_max_o;
  logic [CapW-1:0]          entry_count_o;
  logic [StatW-1:0]         status_o;

  min_max_stack #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_capacity_limit_i(cfg_capacity_limit_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .operation_i         (operation_i),
    .push_value_i        (push_value_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .popped_value_o      (popped_value_o),
    .current_min_o       (current_min_o),
    .current_max_o       (current_max_o),
    .entry_count_o       (entry_count_o),
    .status_o            (status_o)
  );

  // Shadow copy of the stack: encoded words, entry count, extremes, capacity
  logic signed [WordW-1:0] shadow_words [DEPTH];
  int unsigned             shadow_count;
  logic signed [DataW-1:0] shadow_min;
  logic signed [DataW-1:0] shadow_max;
  logic [CapW-1:0]         shadow_cap;

  // Results still owed by the block, oldest first
  stack_result_t pending_results[$];

  int err_count    = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  // Written at a rising edge by a test, picked up at the next falling edge
  int hold_len     = 0;

  // 2 ns clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // Apply one operation to the shadow stack and return what the block must show.
  // A new minimum is stored as 2*value-min, a new maximum as 2*value-max; a pop
  // that finds a word outside [min, max] decodes the previous extreme from it.
  function automatic stack_result_t apply_stack_op(input logic [OpW-1:0] op,
                                                   input logic signed [DataW-1:0] val);
    stack_result_t r;
    int unsigned   lim;
    longint        word;
    r        = '0;
    r.status = ST_OK;
    lim      = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
    case (op)
      OP_PUSH: begin
        if (shadow_count >= lim) begin
          r.status = ST_FULL;
        end else begin
          if (shadow_count == 0) begin
            word       = val;
            shadow_min = val;
            shadow_max = val;
          end else if (val < shadow_min) begin
            word       = 2 * longint'(val) - longint'(shadow_min);
            shadow_min = val;
          end else if (val > shadow_max) begin
            word       = 2 * longint'(val) - longint'(shadow_max);
            shadow_max = val;
          end else begin
            word = val;
          end
          shadow_words[shadow_count] = word[WordW-1:0];
          shadow_count++;
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_count--;
          word     = shadow_words[shadow_count];
          r.popped = word[DataW-1:0];
          if (word < longint'(shadow_min)) begin
            r.popped   = shadow_min;
            word       = 2 * longint'(shadow_min) - word;
            shadow_min = word[DataW-1:0];
          end else if (word > longint'(shadow_max)) begin
            r.popped   = shadow_max;
            word       = 2 * longint'(shadow_max) - word;
            shadow_max = word[DataW-1:0];
          end
        end
      end
      default: begin
        // query and the unused code leave the stack alone
      end
    endcase
    r.min_v  = shadow_min;
    r.max_v  = shadow_max;
    r.count  = shadow_count[CapW-1:0];
    return r;
  endfunction

  // Bias values toward the extremes and toward a narrow band around zero, so
  // that new minima, new maxima and ties all come up often.
  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(9))
      0:       return INT_MAX;
      1:       return INT_MIN;
      2, 3:    return int'($urandom_range(16)) - 8;
      4:       return INT_MAX - int'($urandom_range(15));
      5:       return INT_MIN + int'($urandom_range(15));
      default: return $urandom;
    endcase
  endfunction

  // Lean toward pushes so the stack grows, but pop often enough to decode
  function automatic logic [OpW-1:0] pick_op();
    int unsigned roll;
    roll = $urandom_range(99);
    if (shadow_count == 0) begin
      if (roll < 80) return OP_PUSH;
      if (roll < 95) return OP_POP;
      if (roll < 98) return OP_QUERY;
      return OP_UNUSED;
    end
    if (roll < 52) return OP_PUSH;
    if (roll < 92) return OP_POP;
    if (roll < 97) return OP_QUERY;
    return OP_UNUSED;
  endfunction

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("ERROR at %0t ns: %s got %h expected %h", $time, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [DataW-1:0] got,
                             input logic [DataW-1:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Send one transaction. Called at a falling edge; returns at the falling edge
  // after acceptance with valid still high, so back-to-back items never drop it.
  task automatic send_op(input logic [OpW-1:0] op, input logic signed [DataW-1:0] val);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i   = 1'b0;
      operation_i  = OpW'($urandom);
      push_value_i = $urandom;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    operation_i  = op;
    push_value_i = val;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_results.push_back(apply_stack_op(op, val));
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every owed result has come back
  task automatic wait_drain();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Write the capacity register with the block idle
  task automatic set_capacity(input logic [CapW-1:0] cap);
    wait_drain();
    cfg_we_i             = 1'b1;
    cfg_capacity_limit_i = cap;
    @(negedge clk_i);
    shadow_cap = cap;
    cfg_we_i   = 1'b0;
  endtask

  // Empty pop, query and unused code on the reset state, then encoded pushes
  // at both 32-bit extremes, ties with min and max, a full unwind, and a push
  // onto an emptied stack whose min and max are stale.
  task automatic test_directed_ops();
    send_op(OP_POP, INT_MAX);
    send_op(OP_QUERY, INT_MIN);
    send_op(OP_UNUSED, -1);
    send_op(OP_PUSH, 5);
    send_op(OP_PUSH, -100);
    send_op(OP_PUSH, INT_MIN);
    send_op(OP_PUSH, INT_MAX);
    send_op(OP_PUSH, 7);
    send_op(OP_PUSH, INT_MIN);
    send_op(OP_PUSH, INT_MAX);
    send_op(OP_QUERY, 0);
    send_op(OP_UNUSED, 0);
    repeat (8) send_op(OP_POP, $urandom);
    send_op(OP_POP, 0);
    send_op(OP_PUSH, -3);
    send_op(OP_PUSH, INT_MAX - 1);
    send_op(OP_POP, 0);
    send_op(OP_POP, 0);
  endtask

  // Capacity of one and of zero: refused pushes and refused pops
  task automatic test_capacity_limits();
    set_capacity(8'd1);
    send_op(OP_PUSH, pick_value());
    send_op(OP_PUSH, pick_value());
    send_op(OP_POP, 0);
    send_op(OP_POP, 0);
    set_capacity(8'd0);
    send_op(OP_PUSH, pick_value());
    send_op(OP_POP, 0);
    send_op(OP_QUERY, 0);
    set_capacity(CAP_RESET);
  endtask

  // Lower the capacity below the count: pops go on, pushes are refused until there is room
  task automatic test_capacity_below_count();
    repeat (10) send_op(OP_PUSH, pick_value());
    set_capacity(8'd3);
    send_op(OP_PUSH, pick_value());
    repeat (8) send_op(OP_POP, 0);
    send_op(OP_PUSH, pick_value());
    send_op(OP_PUSH, pick_value());
    repeat (3) send_op(OP_POP, 0);
    set_capacity(CAP_RESET);
  endtask

  // Fill every entry, bounce off the top, then unwind past the bottom
  task automatic test_fill_to_depth();
    set_capacity(CAP_RESET);
    while (shadow_count < DEPTH) send_op(OP_PUSH, pick_value());
    send_op(OP_PUSH, pick_value());
    while (shadow_count > 0) send_op(OP_POP, 0);
    send_op(OP_POP, 0);
  endtask

  // Long receiver hold-off while the sender keeps offering items, so the
  // block backs up and stalls its input
  task automatic test_output_holdoff();
    int saved_idle;
    saved_idle   = snd_idle_pct;
    snd_idle_pct = 0;
    @(posedge clk_i);
    hold_len = 80;
    @(negedge clk_i);
    repeat (16) send_op(pick_op(), pick_value());
    wait_drain();
    snd_idle_pct = saved_idle;
  endtask

  // Random push/pop walks with random content; now and then the sender
  // pauses until everything owed has come back
  task automatic test_random_traffic(input int n_items, input logic [CapW-1:0] cap);
    set_capacity(cap);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(49) == 0) wait_drain();
      send_op(pick_op(), pick_value());
    end
  endtask

  // Receiver stall: a pending hold-off wins, otherwise stall at random
  initial begin : drive_out_stall
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_len > 0) begin
        hold_left = hold_len;
        hold_len  = 0;
      end
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  // Compare each accepted result with the oldest one owed
  always @(posedge clk_i) begin : check_results
    stack_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing owed, status", status_o, '0);
      end else begin
        want = pending_results.pop_front();
        check_field("popped_value", popped_value_o, want.popped);
        check_field("current_min", current_min_o, want.min_v);
        check_field("current_max", current_max_o, want.max_v);
        check_field("entry_count", entry_count_o, want.count);
        check_field("status", status_o, want.status);
      end
    end
  end

  initial begin : run_tests
    shadow_count = 0;
    shadow_min   = INT_MAX;
    shadow_max   = INT_MIN;
    shadow_cap   = CAP_RESET;

    // hold reset, then release it away from the rising edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // sender sparse gaps, receiver stalls often
    snd_idle_pct = 25;
    rcv_idle_pct = 70;
    test_directed_ops();
    test_capacity_limits();
    test_capacity_below_count();
    test_random_traffic(60, 8'd8);

    // the other way round
    snd_idle_pct = 70;
    rcv_idle_pct = 25;
    test_fill_to_depth();
    test_output_holdoff();
    test_random_traffic(60, CAP_RESET);

    // full rate on both sides
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_traffic(20, 8'd1);
    test_random_traffic(50, CapW'($urandom_range(2, 127)));

    wait_drain();
    // let any stray result surface before the final verdict
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", pending_results.size(), '0);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
